/* rtl/core/tcs_pkg.sv */
// Shared types, constants and helpers for the touch calibration and swipe block.
package tcs_pkg;

    localparam int SAMPLES_PER_POLL_DEF = 4;
    localparam int PAIRS_CARRIED        = 4;
    localparam logic [11:0] RAIL_LOW    = 12'd16;
    localparam logic [11:0] RAIL_HIGH   = 12'd4080;
    localparam logic [12:0] SWIPE_MIN   = 13'd30;

    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_ORIENT = 3'd6;

    localparam logic [2:0] GEST_NONE  = 3'd0;
    localparam logic [2:0] GEST_RIGHT = 3'd1;
    localparam logic [2:0] GEST_LEFT  = 3'd2;
    localparam logic [2:0] GEST_DOWN  = 3'd3;
    localparam logic [2:0] GEST_UP    = 3'd4;

    typedef struct packed {
        logic        pen_down;
        logic [2:0]  samples_taken;
        logic [11:0] sample_x_0;
        logic [11:0] sample_y_0;
        logic [11:0] sample_x_1;
        logic [11:0] sample_y_1;
        logic [11:0] sample_x_2;
        logic [11:0] sample_y_2;
        logic [11:0] sample_x_3;
        logic [11:0] sample_y_3;
    } poll_t;

    typedef struct packed {
        logic        pressed;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [2:0]  gesture;
    } point_t;

    typedef struct packed {
        logic        start;
        logic [11:0] raw;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [11:0] size;
        logic        inv;
    } map_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MAP,
        ST_WAIT,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/tcs_lane.sv */
// One sample lane: rail check on an X/Y pair.
module tcs_lane
    import tcs_pkg::*;
(
    input  logic        en,
    input  logic [11:0] x,
    input  logic [11:0] y,
    output logic        ok
);
    assign ok = en && (x >= RAIL_LOW) && (x <= RAIL_HIGH)
                   && (y >= RAIL_LOW) && (y <= RAIL_HIGH);
endmodule

/* rtl/core/tcs_div.sv */
// Iterative unsigned divider, one quotient bit a cycle.
module tcs_div
    import tcs_pkg::*;
#(
    parameter int NW = 24,
    parameter int DW = 13
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

/* rtl/core/tcs_map.sv */
// Axis mapper: signed linear map by iterative division, invert and clamp.
module tcs_map
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  map_req_t    req,
    output logic        done,
    output logic [11:0] coord
);
    logic               neg_reg, neg_next;
    logic               inv_reg, inv_next;
    logic               zero_reg, zero_next;
    logic [11:0]        top_reg, top_next;
    logic               tneg_reg, tneg_next;
    logic [23:0]        prod_reg, prod_next;
    logic [12:0]        den_reg, den_next;
    logic               go_reg, go_next;
    logic               fin_reg, fin_next;
    logic signed [13:0] num_s, den_s;
    logic [12:0]        num_a;
    logic [12:0]        top13;
    logic               dv_done;
    logic [23:0]        dv_q;
    logic signed [25:0] p, t;
    logic [11:0]        coord_reg, coord_next;

    always_comb
    begin
        num_s     = $signed({2'b00, req.raw}) - $signed({2'b00, req.lo});
        den_s     = $signed({2'b00, req.hi}) - $signed({2'b00, req.lo});
        top13     = {1'b0, req.size} - 13'd1;
        num_a     = num_s[13] ? 13'(-num_s) : num_s[12:0];
        neg_next  = neg_reg;
        inv_next  = inv_reg;
        zero_next = zero_reg;
        top_next  = top_reg;
        tneg_next = tneg_reg;
        prod_next = prod_reg;
        den_next  = den_reg;
        go_next   = 1'b0;
        if (req.start)
        begin
            // size 0 gives top of -1; product sign follows both factors
            tneg_next = (req.size == 12'd0);
            top_next  = top13[11:0];
            inv_next  = req.inv;
            zero_next = (den_s == 14'sd0);
            neg_next  = num_s[13] ^ den_s[13] ^ tneg_next;
            prod_next = 24'(num_a) * (tneg_next ? 24'd1 : 24'(top13[11:0]));
            den_next  = den_s[13] ? 13'(-den_s) : den_s[12:0];
            go_next   = 1'b1;
        end
    end

    tcs_div #(.NW(24), .DW(13)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (dv_done),
        .quo   (dv_q)
    );

    always_comb
    begin
        t = tneg_reg ? -26'sd1 : $signed({14'd0, top_reg});
        if (zero_reg)
            p = '0;
        else if (neg_reg)
            p = -$signed({2'b00, dv_q});
        else
            p = $signed({2'b00, dv_q});
        if (inv_reg)
            p = t - p;
        if (p > t)
            p = t;
        if (p < 0)
            p = '0;
        coord_next = dv_done ? p[11:0] : coord_reg;
        fin_next   = dv_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg  <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            go_reg  <= go_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        inv_reg   <= inv_next;
        zero_reg  <= zero_next;
        top_reg   <= top_next;
        tneg_reg  <= tneg_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        coord_reg <= coord_next;
    end

    assign done  = fin_reg;
    assign coord = coord_reg;
endmodule

/* rtl/core/touch_calibrate_and_swipe.sv */
// Top level: poll intake, rail lanes, averaging, axis mapping and swipe detection.
//
//  channel | direction | handshake         | word
//  poll    | in        | poll_valid/ready  | poll_t
//  point   | out       | point_valid/ready | point_t
//  cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// A pressed poll gives its point after two 14-step averaging divisions on one shared
// divider, then both axes mapped in parallel by 24-step dividers. A release poll
// gives its point through the output state, but only if the pen was down; a pressed
// poll with no sample inside the rails gives no point. One poll is in work at a
// time; a new poll waits until the previous point is taken. Reset restores the
// default calibration.
module touch_calibrate_and_swipe
    import tcs_pkg::*;
#(
    parameter int SAMPLES_PER_POLL = SAMPLES_PER_POLL_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        poll_valid,
    output logic        poll_ready,
    input  poll_t       poll,
    output logic        point_valid,
    input  logic        point_ready,
    output point_t      point,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    localparam int LIMIT = (SAMPLES_PER_POLL < PAIRS_CARRIED) ? SAMPLES_PER_POLL
                                                              : PAIRS_CARRIED;

    logic [11:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg, w_reg, h_reg;
    logic [2:0]  ori_reg;
    logic        pwd_reg, pwd_next;
    logic [11:0] lsx_reg, lsx_next, lsy_reg, lsy_next;
    logic [11:0] lrx_reg, lrx_next, lry_reg, lry_next;
    logic [11:0] stx_reg, stx_next, sty_reg, sty_next;
    state_t      st_reg, st_next;
    point_t      out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [13:0] sy_reg, sy_next;
    logic [2:0]  n_reg, n_next;
    logic        ph_reg, ph_next;
    logic [11:0] ax_reg, ax_next;

    logic [11:0] lx [PAIRS_CARRIED];
    logic [11:0] ly [PAIRS_CARRIED];
    logic        lok [PAIRS_CARRIED];
    logic [2:0]  cnt;
    logic [13:0] sx, sy;
    logic [2:0]  n;
    logic        acc;
    logic        dv_start, dv_done;
    logic [13:0] dv_num;
    logic [2:0]  dv_den;
    logic [13:0] dv_q;
    logic [11:0] rx, ry;
    map_req_t    mx, my;
    logic        mx_done, my_done, mx_seen_reg, mx_seen_next, my_seen_reg, my_seen_next;
    logic [11:0] cx, cy;
    logic signed [12:0] dx, dy;
    logic [12:0] adx, ady;
    logic [2:0]  gest;

    assign lx[0] = poll.sample_x_0;  assign ly[0] = poll.sample_y_0;
    assign lx[1] = poll.sample_x_1;  assign ly[1] = poll.sample_y_1;
    assign lx[2] = poll.sample_x_2;  assign ly[2] = poll.sample_y_2;
    assign lx[3] = poll.sample_x_3;  assign ly[3] = poll.sample_y_3;

    assign cnt = (poll.samples_taken > 3'(LIMIT)) ? 3'(LIMIT) : poll.samples_taken;

    for (genvar g = 0; g < PAIRS_CARRIED; g++)
    begin : g_lane
        tcs_lane u_lane
        (
            .en (3'(g) < cnt),
            .x  (lx[g]),
            .y  (ly[g]),
            .ok (lok[g])
        );
    end

    always_comb
    begin
        sx = '0;
        sy = '0;
        n  = '0;
        for (int i = 0; i < PAIRS_CARRIED; i++)
        begin
            if (lok[i])
            begin
                sx = sx + 14'(lx[i]);
                sy = sy + 14'(ly[i]);
                n  = n + 3'd1;
            end
        end
    end

    assign dv_num = (st_reg == ST_IDLE) ? sx : sy_reg;
    assign dv_den = (st_reg == ST_IDLE) ? n : n_reg;

    tcs_div #(.NW(14), .DW(3)) u_avg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_q)
    );

    assign rx = ori_reg[0] ? dv_q[11:0] : ax_reg;
    assign ry = ori_reg[0] ? ax_reg : dv_q[11:0];

    always_comb
    begin
        mx = '{start: 1'b0, raw: rx, lo: xmin_reg, hi: xmax_reg, size: w_reg,
               inv: ori_reg[1]};
        my = '{start: 1'b0, raw: ry, lo: ymin_reg, hi: ymax_reg, size: h_reg,
               inv: ori_reg[2]};
        if (st_reg == ST_AVG && dv_done && ph_reg)
        begin
            mx.start = 1'b1;
            my.start = 1'b1;
        end
    end

    tcs_map u_mapx (.clk(clk), .rst_n(rst_n), .req(mx), .done(mx_done), .coord(cx));
    tcs_map u_mapy (.clk(clk), .rst_n(rst_n), .req(my), .done(my_done), .coord(cy));

    always_comb
    begin
        dx  = $signed({1'b0, lsx_reg}) - $signed({1'b0, stx_reg});
        dy  = $signed({1'b0, lsy_reg}) - $signed({1'b0, sty_reg});
        adx = dx[12] ? 13'(-dx) : dx;
        ady = dy[12] ? 13'(-dy) : dy;
        if (adx < SWIPE_MIN && ady < SWIPE_MIN)
            gest = GEST_NONE;
        else if (adx > ady)
            gest = (!dx[12] && dx != 0) ? GEST_RIGHT : GEST_LEFT;
        else
            gest = (!dy[12] && dy != 0) ? GEST_DOWN : GEST_UP;
    end

    assign acc = poll_valid && poll_ready;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (!poll.pen_down)
                        st_next = pwd_reg ? ST_OUT : ST_IDLE;
                    else
                        st_next = (n != 3'd0) ? ST_AVG : ST_IDLE;
                end
            end
            ST_AVG:  st_next = (dv_done && ph_reg) ? ST_MAP : ST_AVG;
            ST_MAP:  st_next = ST_WAIT;
            ST_WAIT: st_next = ((mx_done || mx_seen_reg) && (my_done || my_seen_reg))
                               ? ST_OUT : ST_WAIT;
            ST_OUT:  st_next = (!ov_reg || point_ready) ? ST_IDLE : ST_OUT;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pwd_next = pwd_reg;
        lsx_next = lsx_reg;  lsy_next = lsy_reg;
        lrx_next = lrx_reg;  lry_next = lry_reg;
        stx_next = stx_reg;  sty_next = sty_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !point_ready;
        sy_next  = sy_reg;  n_next = n_reg;
        ph_next  = ph_reg;  ax_next = ax_reg;
        dv_start = 1'b0;
        mx_seen_next = mx_seen_reg;
        my_seen_next = my_seen_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (acc && poll.pen_down && n != 3'd0)
                begin
                    sy_next  = sy;
                    n_next   = n;
                    ph_next  = 1'b0;
                    dv_start = 1'b1;
                end
                else if (acc && !poll.pen_down && pwd_reg)
                begin
                    pwd_next = 1'b0;
                    out_next = '{pressed: 1'b0, screen_x: lsx_reg, screen_y: lsy_reg,
                                 raw_x: lrx_reg, raw_y: lry_reg, gesture: GEST_NONE};
                end
            end
            ST_AVG:
            begin
                if (dv_done && !ph_reg)
                begin
                    ax_next  = dv_q[11:0];
                    ph_next  = 1'b1;
                    dv_start = 1'b1;
                end
                else if (dv_done)
                begin
                    lrx_next = rx;
                    lry_next = ry;
                    mx_seen_next = 1'b0;
                    my_seen_next = 1'b0;
                end
            end
            ST_MAP: ;
            ST_WAIT:
            begin
                if (mx_done) mx_seen_next = 1'b1;
                if (my_done) my_seen_next = 1'b1;
                if ((mx_done || mx_seen_reg) && (my_done || my_seen_reg))
                begin
                    lsx_next = cx;
                    lsy_next = cy;
                    if (!pwd_reg)
                    begin
                        stx_next = cx;
                        sty_next = cy;
                    end
                    pwd_next = 1'b1;
                    out_next = '{pressed: 1'b1, screen_x: cx, screen_y: cy,
                                 raw_x: lrx_reg, raw_y: lry_reg, gesture: GEST_NONE};
                end
            end
            ST_OUT:
            begin
                if (!out_reg.pressed)
                    out_next.gesture = gest;
                if (!ov_reg || point_ready)
                    ov_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign poll_ready  = (st_reg == ST_IDLE) && !ov_reg;
    assign cfg_ready   = 1'b1;
    assign point_valid = ov_reg;
    assign point       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= 12'd300;
            xmax_reg <= 12'd3800;
            ymin_reg <= 12'd300;
            ymax_reg <= 12'd3800;
            w_reg    <= 12'd320;
            h_reg    <= 12'd240;
            ori_reg  <= 3'd5;
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            pwd_reg  <= 1'b0;
            lsx_reg  <= '0;  lsy_reg <= '0;
            lrx_reg  <= '0;  lry_reg <= '0;
            stx_reg  <= '0;  sty_reg <= '0;
            mx_seen_reg <= 1'b0;
            my_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_X_MIN:  xmin_reg <= cfg_data;
                    REG_X_MAX:  xmax_reg <= cfg_data;
                    REG_Y_MIN:  ymin_reg <= cfg_data;
                    REG_Y_MAX:  ymax_reg <= cfg_data;
                    REG_WIDTH:  w_reg    <= cfg_data;
                    REG_HEIGHT: h_reg    <= cfg_data;
                    REG_ORIENT: ori_reg  <= cfg_data[2:0];
                    default: ;
                endcase
            end
            st_reg  <= st_next;
            ov_reg  <= ov_next;
            pwd_reg <= pwd_next;
            lsx_reg <= lsx_next;  lsy_reg <= lsy_next;
            lrx_reg <= lrx_next;  lry_reg <= lry_next;
            stx_reg <= stx_next;  sty_reg <= sty_next;
            mx_seen_reg <= mx_seen_next;
            my_seen_reg <= my_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sy_reg  <= sy_next;
        n_reg   <= n_next;
        ph_reg  <= ph_next;
        ax_reg  <= ax_next;
    end
endmodule
